// ===== src/lfpd_pkg.sv =====
// Shared constants and codes for the line follower PD controller.
`default_nettype none

package lfpd_pkg;

    // Drive ceiling and the sensor count that makes a marker.
    localparam int PWM_MAX            = 999;
    localparam int MARKER_MIN_SENSORS = 4;

    // Field widths.
    localparam int SENSOR_W = 5;
    localparam int TIME_W   = 32;
    localparam int SPEED_W  = 10;
    localparam int GAIN_W   = 10;
    localparam int MS_W     = 16;
    localparam int DRIVE_W  = 10;
    localparam int PHASE_W  = 2;
    localparam int ERR_W    = 3;
    localparam int DIR_W    = 2;
    localparam int CNT_W    = 3;

    // Config port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 40;   // 5 + 32 = 37 used
    localparam int OUT_TDATA_W = 24;   // 10 + 10 + 1 + 2 = 23 used

    // Signed width for the drive arithmetic: holds base +/- correction and PWM_MAX.
    localparam int SUM_W  = 18;
    localparam int PROD_W = 14;

    localparam logic signed [SUM_W-1:0] PWM_MAX_S = SUM_W'(PWM_MAX);

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_SPEED = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SPEED    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MARKER_HOLD  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_START_IGNORE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN     = 3'd7;

    // Mission phases.
    localparam logic [PHASE_W-1:0] PH_INIT   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

    // Search directions.
    localparam logic [DIR_W-1:0] DIR_STRAIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd2;

endpackage

`default_nettype wire

// ===== src/line_follow_pd_with_checkpoints_top.sv =====
// Five-sensor line follower: PD steering, line search and checkpoint sequencer.
`default_nettype none

// Takes one beat per control tick on the slave side (five sensor bits plus a
// millisecond timestamp) and returns exactly one result beat per input beat on
// the master side: left and right wheel drive, a beep request and the mission
// phase after the tick. Each beat goes through an input register and a result
// register with the combinational steering and marker logic between them. A new
// beat can be taken every cycle while the result side does not stall; the
// mission state (phase, last error, search direction, marker timers) is updated
// on the same edge that loads the beat into the result register.
// s_tready stays high while the result register drains or is empty, so a
// stalled result only holds back one waiting input beat. The first beat after
// reset is the init tick: drives zero, beep high, phase moves to 1. Phase
// advances (drives zero, beep high) happen on a qualified marker once the
// start ignore time has passed; in the finished phase the drives stay zero.
// The user must write registers through cfg_we/cfg_addr/cfg_wdata only while
// the block is idle; the block itself does not enforce this. Unknown indexes
// cannot occur and wider data is truncated to the register.
module line_follow_pd_with_checkpoints_top
    import lfpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [4:0] sensor_bits, [36:5] time_ms, [39:37] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [9:0] left_drive, [19:10] right_drive, [20] beep_pulse, [22:21] phase, [23] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    // ---------------- configuration ----------------
    logic [SPEED_W-1:0] base_speed_reg;
    logic [SPEED_W-1:0] search_speed_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [MS_W-1:0]    marker_hold_reg;
    logic [MS_W-1:0]    start_ignore_reg;
    logic [MS_W-1:0]    cooldown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg   <= SPEED_W'(620);
            search_speed_reg <= SPEED_W'(430);
            min_speed_reg    <= SPEED_W'(320);
            gain_p_reg       <= GAIN_W'(85);
            gain_d_reg       <= GAIN_W'(35);
            marker_hold_reg  <= MS_W'(60);
            start_ignore_reg <= MS_W'(1200);
            cooldown_reg     <= MS_W'(700);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_BASE_SPEED:   base_speed_reg   <= cfg_wdata[SPEED_W-1:0];
                REG_SEARCH_SPEED: search_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_MIN_SPEED:    min_speed_reg    <= cfg_wdata[SPEED_W-1:0];
                REG_GAIN_P:       gain_p_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:       gain_d_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_MARKER_HOLD:  marker_hold_reg  <= cfg_wdata[MS_W-1:0];
                REG_START_IGNORE: start_ignore_reg <= cfg_wdata[MS_W-1:0];
                REG_COOLDOWN:     cooldown_reg     <= cfg_wdata[MS_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [SENSOR_W-1:0] sensor_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                step;

    // step: the input register's beat moves into the result register
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            sensor_reg <= s_tdata[SENSOR_W-1:0];
            time_reg   <= s_tdata[SENSOR_W+TIME_W-1:SENSOR_W];
        end
    end

    // ---------------- mission state ----------------
    logic [PHASE_W-1:0]       phase_reg,        phase_next;
    logic signed [ERR_W-1:0]  prev_err_reg,     prev_err_next;
    logic [DIR_W-1:0]         dir_reg,          dir_next;
    logic [TIME_W-1:0]        phase_start_reg,  phase_start_next;
    logic [TIME_W-1:0]        marker_start_reg, marker_start_next;
    logic [TIME_W-1:0]        last_accept_reg,  last_accept_next;
    logic                     marker_seen_reg,  marker_seen_next;

    // ---------------- steering datapath ----------------
    logic [CNT_W-1:0]          sensor_cnt;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W:0]     err_delta;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_d;
    logic signed [SUM_W-1:0]   corr;
    logic signed [SUM_W-1:0]   base_s;
    logic [DRIVE_W-1:0]        follow_left;
    logic [DRIVE_W-1:0]        follow_right;

    function automatic logic [DRIVE_W-1:0] limit_top(input logic [SPEED_W-1:0] v);
        logic signed [SUM_W-1:0] vs;
        vs = SUM_W'({1'b0, v});
        if (vs > PWM_MAX_S)
        begin
            vs = PWM_MAX_S;
        end
        return DRIVE_W'(vs);
    endfunction

    // clamp to 0..PWM_MAX, raise to the floor, cap at PWM_MAX again
    function automatic logic [DRIVE_W-1:0] drive_clamp(input logic signed [SUM_W-1:0] v,
                                                       input logic [SPEED_W-1:0] floor_v);
        logic signed [SUM_W-1:0] c;
        logic signed [SUM_W-1:0] f;
        c = v;
        f = SUM_W'({1'b0, floor_v});
        if (c < 0)
        begin
            c = '0;
        end
        if (c > PWM_MAX_S)
        begin
            c = PWM_MAX_S;
        end
        if (c < f)
        begin
            c = f;
        end
        if (c > PWM_MAX_S)
        begin
            c = PWM_MAX_S;
        end
        return DRIVE_W'(c);
    endfunction

    always_comb
    begin
        // weights -2,-1,0,+1,+2 from the left
        sensor_cnt = CNT_W'(sensor_reg[0]) + CNT_W'(sensor_reg[1]) + CNT_W'(sensor_reg[2])
                   + CNT_W'(sensor_reg[3]) + CNT_W'(sensor_reg[4]);
        err = ERR_W'(0);
        if (sensor_reg[0]) err = err - ERR_W'(2);
        if (sensor_reg[1]) err = err - ERR_W'(1);
        if (sensor_reg[3]) err = err + ERR_W'(1);
        if (sensor_reg[4]) err = err + ERR_W'(2);
        err_delta = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err_reg);
        prod_p = $signed({1'b0, gain_p_reg}) * PROD_W'(err);
        prod_d = $signed({1'b0, gain_d_reg}) * PROD_W'(err_delta);
        corr   = SUM_W'(prod_p) + SUM_W'(prod_d);
        base_s = SUM_W'({1'b0, base_speed_reg});
        follow_left  = drive_clamp(base_s - corr, min_speed_reg);
        follow_right = drive_clamp(base_s + corr, min_speed_reg);
    end

    // ---------------- tick update ----------------
    logic               marker_now;
    logic               ready_mark;
    logic [TIME_W-1:0]  now;
    logic [DRIVE_W-1:0] left_next;
    logic [DRIVE_W-1:0] right_next;
    logic               beep_next;

    assign now        = time_reg;
    assign marker_now = sensor_cnt >= CNT_W'(MARKER_MIN_SENSORS);

    always_comb
    begin
        phase_next        = phase_reg;
        prev_err_next     = prev_err_reg;
        dir_next          = dir_reg;
        phase_start_next  = phase_start_reg;
        marker_start_next = marker_start_reg;
        last_accept_next  = last_accept_reg;
        marker_seen_next  = marker_seen_reg;
        left_next         = '0;
        right_next        = '0;
        beep_next         = 1'b0;
        ready_mark        = 1'b0;

        if (phase_reg == PH_INIT)
        begin
            beep_next        = 1'b1;
            phase_start_next = now;
            last_accept_next = '0;
            marker_seen_next = 1'b0;
            phase_next       = PH_FIRST;
        end
        else
        begin
            // marker qualification runs in every phase but init
            marker_seen_next = marker_now;
            if (marker_now && !marker_seen_reg)
            begin
                marker_start_next = now;
            end
            ready_mark = marker_now
                      && (now - marker_start_next) >= TIME_W'(marker_hold_reg)
                      && (now - last_accept_reg) >= TIME_W'(cooldown_reg);
            if (ready_mark)
            begin
                last_accept_next = now;
            end

            if (phase_reg == PH_FIRST || phase_reg == PH_SECOND)
            begin
                if (sensor_cnt == '0)
                begin
                    // line lost: steer toward the last side seen, or stop if it was straight ahead
                    case (dir_reg)
                        DIR_RIGHT:
                        begin
                            left_next  = limit_top(search_speed_reg);
                            right_next = limit_top(base_speed_reg);
                        end
                        DIR_LEFT:
                        begin
                            left_next  = limit_top(base_speed_reg);
                            right_next = limit_top(search_speed_reg);
                        end
                        default:
                        begin
                            left_next  = '0;
                            right_next = '0;
                        end
                    endcase
                end
                else
                begin
                    left_next     = follow_left;
                    right_next    = follow_right;
                    prev_err_next = err;
                    if (err > 0)
                    begin
                        dir_next = DIR_RIGHT;
                    end
                    else if (err < 0)
                    begin
                        dir_next = DIR_LEFT;
                    end
                    else
                    begin
                        dir_next = DIR_STRAIGHT;
                    end
                end

                if ((now - phase_start_reg) > TIME_W'(start_ignore_reg) && ready_mark)
                begin
                    left_next        = '0;
                    right_next       = '0;
                    beep_next        = 1'b1;
                    phase_start_next = now;
                    marker_seen_next = 1'b0;
                    phase_next       = phase_reg + PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_INIT;
            prev_err_reg     <= '0;
            dir_reg          <= DIR_STRAIGHT;
            phase_start_reg  <= '0;
            marker_start_reg <= '0;
            last_accept_reg  <= '0;
            marker_seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            prev_err_reg     <= prev_err_next;
            dir_reg          <= dir_next;
            phase_start_reg  <= phase_start_next;
            marker_start_reg <= marker_start_next;
            last_accept_reg  <= last_accept_next;
            marker_seen_reg  <= marker_seen_next;
        end
    end

    // ---------------- result register ----------------
    logic [DRIVE_W-1:0] left_reg;
    logic [DRIVE_W-1:0] right_reg;
    logic               beep_reg;
    logic [PHASE_W-1:0] out_phase_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            beep_reg      <= beep_next;
            out_phase_reg <= phase_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_phase_reg, beep_reg, right_reg, left_reg};

    // ---------------- assertions ----------------
    // a beep beat always carries stopped drives
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && beep_reg |-> left_reg == '0 && right_reg == '0)
        else $error("beep beat with nonzero drive");

    // finished phase reports stopped drives
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_phase_reg == PH_DONE |-> left_reg == '0 && right_reg == '0)
        else $error("drive active in finished phase");

    // finished phase is final
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("left finished phase");

    // after any processed tick the block is past init
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> phase_reg != PH_INIT)
        else $error("phase back in init after a tick");

    // input side only stalls when a beat is parked in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without backpressure");

endmodule

`default_nettype wire

// ===== sim/line_follow_pd_with_checkpoints_top_tb.sv =====
// Self-checking testbench for the line follower PD controller with checkpoint phases.
`default_nettype none

module line_follow_pd_with_checkpoints_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpd_pkg::*;

    // Cycles with no beat on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Stretch of the long output hold-off used to back the block up.
    localparam int HOLD_OFF_CYCLES = 60;
    // Keep the log readable if the design is badly broken.
    localparam int MAX_REPORTS = 50;

    // Sweep of every line position and the lost-line cases for the opening checks.
    localparam logic [SENSOR_W-1:0] LINE_WALK [11] = '{
        5'b00000, 5'b00001, 5'b00000, 5'b10000, 5'b00000, 5'b00010,
        5'b00100, 5'b01000, 5'b11000, 5'b00011, 5'b10001
    };

    // One output beat, unpacked.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               beep;
        logic [DRIVE_W-1:0] right;
        logic [DRIVE_W-1:0] left;
    } tick_result_t;

    // Mirror of the controller: register copies, mission state, and the drive
    // results still owed by the block, oldest first.
    class mission_tracker;
        logic [SPEED_W-1:0] base_speed, search_speed, min_speed;
        logic [GAIN_W-1:0]  gain_p, gain_d;
        logic [MS_W-1:0]    marker_hold, start_ignore, cooldown;

        logic [PHASE_W-1:0] mission;
        int                 last_err;
        logic [DIR_W-1:0]   heading;
        logic [TIME_W-1:0]  phase_start, marker_start, last_accept;
        bit                 marker_seen;

        tick_result_t       owed_drives[$];
        int                 mismatches;

        function new();
            base_speed   = 620;
            search_speed = 430;
            min_speed    = 320;
            gain_p       = 85;
            gain_d       = 35;
            marker_hold  = 60;
            start_ignore = 1200;
            cooldown     = 700;
            mission      = PH_INIT;
            last_err     = 0;
            heading      = DIR_STRAIGHT;
            phase_start  = '0;
            marker_start = '0;
            last_accept  = '0;
            marker_seen  = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_reg(input logic [CFG_ADDR_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BASE_SPEED:   base_speed   = val[SPEED_W-1:0];
                REG_SEARCH_SPEED: search_speed = val[SPEED_W-1:0];
                REG_MIN_SPEED:    min_speed    = val[SPEED_W-1:0];
                REG_GAIN_P:       gain_p       = val[GAIN_W-1:0];
                REG_GAIN_D:       gain_d       = val[GAIN_W-1:0];
                REG_MARKER_HOLD:  marker_hold  = val[MS_W-1:0];
                REG_START_IGNORE: start_ignore = val[MS_W-1:0];
                REG_COOLDOWN:     cooldown     = val[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function int cap(input int v);
            return (v > PWM_MAX) ? PWM_MAX : v;
        endfunction

        // PD steering, or the search drive when no sensor sees the line.
        function void steer(input logic [SENSOR_W-1:0] bits,
                            output logic [DRIVE_W-1:0] l_drv,
                            output logic [DRIVE_W-1:0] r_drv);
            int err, corr, l, r;
            err = 0;
            if (bits[0]) err -= 2;
            if (bits[1]) err -= 1;
            if (bits[3]) err += 1;
            if (bits[4]) err += 2;
            if (bits == '0)
            begin
                l = 0;
                r = 0;
                if (heading == DIR_RIGHT)
                begin
                    l = cap(int'(search_speed));
                    r = cap(int'(base_speed));
                end
                else if (heading == DIR_LEFT)
                begin
                    l = cap(int'(base_speed));
                    r = cap(int'(search_speed));
                end
                l_drv = l[DRIVE_W-1:0];
                r_drv = r[DRIVE_W-1:0];
                return;
            end
            corr = int'(gain_p) * err + int'(gain_d) * (err - last_err);
            l = int'(base_speed) - corr;
            r = int'(base_speed) + corr;
            if (l < 0) l = 0;
            if (l > PWM_MAX) l = PWM_MAX;
            if (r < 0) r = 0;
            if (r > PWM_MAX) r = PWM_MAX;
            if (l < int'(min_speed)) l = int'(min_speed);
            if (r < int'(min_speed)) r = int'(min_speed);
            l = cap(l);
            r = cap(r);
            l_drv = l[DRIVE_W-1:0];
            r_drv = r[DRIVE_W-1:0];
            heading = (err > 0) ? DIR_RIGHT : ((err < 0) ? DIR_LEFT : DIR_STRAIGHT);
            last_err = err;
        endfunction

        // Called for each accepted input beat; queues the drive result it owes.
        function void note_tick(input logic [SENSOR_W-1:0] bits,
                                input logic [TIME_W-1:0] now);
            tick_result_t      want;
            bit                ready;
            logic [TIME_W-1:0] held, since_accept, since_start;
            want  = '0;
            ready = 1'b0;
            if (mission == PH_INIT)
            begin
                // first tick: announce start, no marker logic
                want.beep   = 1'b1;
                phase_start = now;
                last_accept = '0;
                marker_seen = 1'b0;
                mission     = PH_FIRST;
            end
            else
            begin
                if ($countones(bits) >= MARKER_MIN_SENSORS)
                begin
                    if (!marker_seen)
                    begin
                        marker_seen  = 1'b1;
                        marker_start = now;
                    end
                end
                else
                    marker_seen = 1'b0;
                held         = now - marker_start;
                since_accept = now - last_accept;
                if (marker_seen && held >= TIME_W'(marker_hold)
                    && since_accept >= TIME_W'(cooldown))
                begin
                    ready       = 1'b1;
                    last_accept = now;
                end
                if (mission == PH_FIRST || mission == PH_SECOND)
                begin
                    steer(bits, want.left, want.right);
                    since_start = now - phase_start;
                    if (since_start > TIME_W'(start_ignore) && ready)
                    begin
                        want.left   = '0;
                        want.right  = '0;
                        want.beep   = 1'b1;
                        phase_start = now;
                        marker_seen = 1'b0;
                        mission     = mission + PHASE_W'(1);
                    end
                end
            end
            want.phase = mission;
            owed_drives.push_back(want);
        endfunction

        function void report(input string field, input int want, input int got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        // Called for each accepted output beat.
        function void check_drive(input logic [OUT_TDATA_W-1:0] beat);
            tick_result_t want, got;
            got = beat[$bits(tick_result_t)-1:0];
            if (owed_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: output beat with no tick pending, expected none, got 0x%06h",
                             $time, beat);
                return;
            end
            want = owed_drives.pop_front();
            if (got.left != want.left)   report("left_drive", want.left, got.left);
            if (got.right != want.right) report("right_drive", want.right, got.right);
            if (got.beep != want.beep)   report("beep_pulse", want.beep, got.beep);
            if (got.phase != want.phase) report("phase", want.phase, got.phase);
        endfunction

        function int pending();
            return owed_drives.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [4:0] sensor_bits, [36:5] time_ms, [39:37] zero
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [9:0] left_drive, [19:10] right_drive, [20] beep_pulse, [22:21] phase, [23] zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    mission_tracker tracker = new();

    // Pacing knobs shared by the driver processes.
    bit                tx_idle_on = 1'b1;
    bit                rx_idle_on = 1'b1;
    bit                stall_req  = 1'b0;   // one-shot long hold-off on the output side
    bit                wild_time  = 1'b0;   // allow timestamp jumps anywhere in 32 bits
    logic [TIME_W-1:0] clock_ms;

    line_follow_pd_with_checkpoints_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one tick after a random gap and hold it until the block takes it.
    // Called at a rising edge; returns at the edge where the beat was accepted.
    task automatic send_tick(input logic [SENSOR_W-1:0] bits, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({stamp, bits});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.note_tick(bits, stamp);
    endtask

    task automatic step_tick(input logic [SENSOR_W-1:0] bits, input int step);
        clock_ms += TIME_W'(step);
        send_tick(bits, clock_ms);
    endtask

    task automatic advance(input logic [SENSOR_W-1:0] bits, input int step_hi);
        if (wild_time && $urandom_range(0, 15) == 0)
            clock_ms = $urandom;
        else
            clock_ms += TIME_W'($urandom_range(0, step_hi));
        send_tick(bits, clock_ms);
    endtask

    // Stop offering and wait until the block has returned every owed beat.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] base_v, search_v, min_v,
                                  input logic [CFG_DATA_W-1:0] kp_v, kd_v,
                                  input logic [CFG_DATA_W-1:0] hold_v, ignore_v, cool_v);
        write_reg(REG_BASE_SPEED, base_v);
        write_reg(REG_SEARCH_SPEED, search_v);
        write_reg(REG_MIN_SPEED, min_v);
        write_reg(REG_GAIN_P, kp_v);
        write_reg(REG_GAIN_D, kd_v);
        write_reg(REG_MARKER_HOLD, hold_v);
        write_reg(REG_START_IGNORE, ignore_v);
        write_reg(REG_COOLDOWN, cool_v);
        cfg_we <= 1'b0;
    endtask

    // On-line sensor patterns: one sensor, two adjacent ones, or the line lost.
    function automatic logic [SENSOR_W-1:0] line_bits();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 5'b00001 << pick;
        if (pick < 9)
            return 5'b00011 << (pick - 5);
        return 5'b00000;
    endfunction

    // Cross-line marks: four or five sensors lit.
    function automatic logic [SENSOR_W-1:0] marker_bits();
        case ($urandom_range(0, 5))
            0:       return 5'b11111;
            1:       return 5'b11110;
            2:       return 5'b01111;
            3:       return 5'b10111;
            4:       return 5'b11011;
            default: return 5'b11101;
        endcase
    endfunction

    // Mostly line following and held marks with random content; some raw noise.
    task automatic run_segment(input int n, input int step_hi);
        int sent, run_len, mode;
        sent = 0;
        while (sent < n)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 50)
            begin
                run_len = $urandom_range(1, 6);
                repeat (run_len)
                begin
                    advance(line_bits(), step_hi);
                    sent++;
                end
            end
            else if (mode < 80)
            begin
                // a mark held for a while, then back on the line
                run_len = $urandom_range(1, 10);
                repeat (run_len)
                begin
                    advance(marker_bits(), step_hi);
                    sent++;
                end
                advance(line_bits(), step_hi);
                sent++;
            end
            else
            begin
                advance(SENSOR_W'($urandom), step_hi);
                sent++;
            end
        end
    endtask

    // Output side: random ready gaps per beat, plus one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        forever
        begin
            if (stall_req)
            begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            gap = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            tracker.check_drive(m_tdata);
        end
    end

    // Hang detector: any beat on either side restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening checks with the reset settings. The start tick carries a full
        // mark, which must be ignored; the timestamp sits at its top value so
        // the following ticks wrap through zero.
        clock_ms = '1;
        send_tick(5'b11111, clock_ms);
        // every line position, and the lost line after straight, left and right
        foreach (LINE_WALK[i])
            step_tick(LINE_WALK[i], 10);
        // a mark that qualifies on hold time but not yet on cooldown, then broken
        repeat (3) step_tick(5'b11111, 30);
        step_tick(5'b01110, 30);
        // a held mark: accepted inside the start-ignore window first, then
        // advancing to the second leg, then re-armed after the advance
        repeat (6) step_tick(5'b01111, 400);
        step_tick(5'b10100, 10);
        drain();

        // Nominal gains, start-ignore at its top so the leg never ends here.
        apply_settings(620, 430, 320, 85, 35, 60, 16'hFFFF, 700);
        run_segment(70, 100);
        // hold the output side off while ticks keep coming, so the block backs up
        stall_req = 1'b1;
        run_segment(30, 100);
        // pause the input until the backlog is fully drained
        drain();
        run_segment(50, 100);
        drain();

        // Top speeds and gains, zero floor, marks accepted immediately. Gain P is
        // written with all data bits set to exercise truncation. No idle gaps.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_settings(999, 999, 0, 16'hFFFF, 1023, 0, 16'hFFFF, 0);
        run_segment(100, 40);
        drain();

        // Zero speeds and gains, floor at the top, every timer at its maximum.
        tx_idle_on = 1'b1;
        apply_settings(0, 0, 999, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_segment(60, 20);
        drain();

        // Random mid-range settings.
        rx_idle_on = 1'b1;
        apply_settings(16'($urandom_range(0, 999)), 16'($urandom_range(0, 999)),
                       16'($urandom_range(0, 999)), 16'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 1023)), 16'($urandom_range(0, 200)),
                       16'hFFFF, 16'($urandom_range(0, 300)));
        run_segment(140, 60);
        drain();

        // No start-ignore: the next qualified mark finishes the run, after which
        // the marker logic keeps running with the drives held at zero.
        wild_time = 1'b1;
        apply_settings(16'($urandom_range(0, 999)), 16'($urandom_range(0, 999)),
                       16'($urandom_range(0, 999)), 16'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 1023)), 16'($urandom_range(0, 50)),
                       0, 100);
        run_segment(80, 100);
        drain();

        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
